FILE: rtl/core/srt_pkg.sv
// srt_pkg: shared types and constants of the service registry ttl table
// used by service_registry_ttl_table_unit and the testbench; no dependencies
package srt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = 4;
    localparam int EXP_W   = 5;
    localparam int LIFE_W  = 24;

    typedef enum logic [1:0] {
        FUNC_OFFER  = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_UPDATED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_EVICTED  = 3'd2,
        STAT_REMOVED  = 3'd3,
        STAT_IGNORED  = 3'd4,
        STAT_TICK     = 3'd5,
        STAT_HIT      = 3'd6,
        STAT_MISS     = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    // input transaction payload, last member in the lowest bits
    typedef struct packed {
        logic [15:0]       elapsed_seconds;
        logic [15:0]       port;
        logic [31:0]       ipv4;
        logic [LIFE_W-1:0] ttl;
        logic [7:0]        minor;
        logic [7:0]        major;
        logic [15:0]       inst;
        logic [15:0]       srv;
    } in_t;

    // output transaction payload, padded to whole bytes
    typedef struct packed {
        logic [6:0]        pad;
        logic [EXP_W-1:0]  expired_count;
        logic [LIFE_W-1:0] remaining_ttl;
        logic [7:0]        found_minor;
        logic [15:0]       found_port;
        logic [31:0]       found_ipv4;
        logic [SLOT_W-1:0] slot;
    } out_t;

    // one table entry as kept in the entry ram
    typedef struct packed {
        logic [LIFE_W-1:0] life;
        logic [15:0]       port;
        logic [31:0]       address;
        logic [7:0]        minor;
        logic [7:0]        major;
        logic [15:0]       inst;
        logic [15:0]       srv;
    } entry_t;

    localparam int IN_W    = $bits(in_t);
    localparam int OUT_W   = $bits(out_t);
    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/service_registry_ttl_table_unit.sv
// service_registry_ttl_table_unit: table of remote services with lifetimes
// depends on srt_pkg and srt_ram
//
// Each offer, tick or lookup walks the whole table through the single read
// port of the entry ram, one entry per cycle, with one compare/subtract unit
// doing the key match, the smallest-lifetime search or the lifetime
// decrement for that entry. The unused func code skips the walk and goes
// straight to the result. The input is not ready while an item is being
// worked on. A finished result sits in an output register, so the next
// transaction is accepted even while the result still waits for m_tready.
// Key and endpoint fields live in the ram and are only read behind a set
// valid bit; valid bits are flip-flops cleared by reset, so no clearing
// pass is needed.
module service_registry_ttl_table_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // srv, inst, major, minor, ttl, ipv4, port, elapsed_seconds
    input  logic [srt_pkg::IN_W-1:0]    s_tdata,
    // func
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // slot, found_ipv4, found_port, found_minor, remaining_ttl, expired_count
    output logic [srt_pkg::OUT_W-1:0]   m_tdata,
    // status
    output logic [2:0]                  m_tuser
);

    import srt_pkg::*;

    state_t               state_reg, state_next;
    logic [IDX_W:0]       rd_cnt_reg, rd_cnt_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    func_t                func_reg, func_next;
    in_t                  in_reg, in_next;
    logic                 match_found_reg, match_found_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 min_found_reg, min_found_next;
    logic [IDX_W-1:0]     min_idx_reg, min_idx_next;
    logic [LIFE_W-1:0]    min_life_reg, min_life_next;
    entry_t               found_reg, found_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_user_reg, out_user_next;
    out_t                 out_data_reg, out_data_next;

    logic                 s_fire;
    logic                 issue;
    logic                 done_fire;
    logic                 ent_valid;
    logic                 key_hit;
    logic [LIFE_W-1:0]    elapsed_ext;
    logic [LIFE_W-1:0]    life_dec;
    entry_t               ent;
    entry_t               new_ent;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic [IDX_W-1:0]     target_idx;

    srt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_cnt_reg[IDX_W-1:0]),
        .rd_data (ent)
    );

    // handshake and shared compare/subtract unit
    always_comb
    begin
        s_tready    = (state_reg == S_IDLE);
        s_fire      = s_tvalid && s_tready;
        issue       = (state_reg == S_SCAN) && (rd_cnt_reg < (IDX_W + 1)'(ENTRIES));
        done_fire   = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
        ent_valid   = valid_reg[chk_idx_reg];
        key_hit     = ent_valid && (ent.srv == in_reg.srv)
                      && (ent.inst == in_reg.inst)
                      && (ent.major == in_reg.major);
        elapsed_ext = LIFE_W'(in_reg.elapsed_seconds);
        life_dec    = (ent.life > elapsed_ext) ? (ent.life - elapsed_ext) : '0;
        target_idx  = match_found_reg ? match_idx_reg
                      : (free_found_reg ? free_idx_reg : min_idx_reg);
        new_ent.life    = in_reg.ttl;
        new_ent.port    = in_reg.port;
        new_ent.address = in_reg.ipv4;
        new_ent.minor   = in_reg.minor;
        new_ent.major   = in_reg.major;
        new_ent.inst    = in_reg.inst;
        new_ent.srv     = in_reg.srv;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = (func_t'(s_tuser) == FUNC_NONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue && !chk_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rd_cnt_next      = rd_cnt_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        valid_next       = valid_reg;
        func_next        = func_reg;
        in_next          = in_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        min_found_next   = min_found_reg;
        min_idx_next     = min_idx_reg;
        min_life_next    = min_life_reg;
        found_next       = found_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_user_next    = out_user_reg;
        out_data_next    = out_data_reg;
        wr_en            = 1'b0;
        wr_addr          = chk_idx_reg;
        wr_data          = ent;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    in_next          = in_t'(s_tdata);
                    func_next        = func_t'(s_tuser);
                    rd_cnt_next      = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    min_found_next   = 1'b0;
                    cnt_next         = '0;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_cnt_reg[IDX_W-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (func_reg == FUNC_TICK)
                    begin
                        if (ent_valid)
                        begin
                            // write back the decremented lifetime
                            wr_en        = 1'b1;
                            wr_data      = ent;
                            wr_data.life = life_dec;
                            if (life_dec == '0)
                            begin
                                valid_next[chk_idx_reg] = 1'b0;
                                cnt_next                = cnt_reg + 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (key_hit && !match_found_reg)
                        begin
                            match_found_next = 1'b1;
                            match_idx_next   = chk_idx_reg;
                            found_next       = ent;
                        end
                        if (!ent_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                        // strict less keeps the lowest index on ties
                        if (ent_valid && (!min_found_reg || (ent.life < min_life_reg)))
                        begin
                            min_found_next = 1'b1;
                            min_idx_next   = chk_idx_reg;
                            min_life_next  = ent.life;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (done_fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_user_next  = STAT_IGNORED;
                    case (func_reg)
                        FUNC_OFFER:
                        begin
                            if (match_found_reg)
                            begin
                                out_data_next.slot = SLOT_W'(match_idx_reg);
                                if (in_reg.ttl == '0)
                                begin
                                    valid_next[match_idx_reg] = 1'b0;
                                    out_user_next             = STAT_REMOVED;
                                end
                                else
                                begin
                                    wr_en         = 1'b1;
                                    wr_addr       = match_idx_reg;
                                    wr_data       = new_ent;
                                    out_user_next = STAT_UPDATED;
                                end
                            end
                            else if (in_reg.ttl != '0)
                            begin
                                wr_en                  = 1'b1;
                                wr_addr                = target_idx;
                                wr_data                = new_ent;
                                valid_next[target_idx] = 1'b1;
                                out_data_next.slot     = SLOT_W'(target_idx);
                                out_user_next = free_found_reg ? STAT_INSERTED : STAT_EVICTED;
                            end
                        end
                        FUNC_TICK:
                        begin
                            out_user_next               = STAT_TICK;
                            out_data_next.expired_count = EXP_W'(cnt_reg);
                        end
                        FUNC_LOOKUP:
                        begin
                            if (match_found_reg)
                            begin
                                out_user_next               = STAT_HIT;
                                out_data_next.slot          = SLOT_W'(match_idx_reg);
                                out_data_next.found_ipv4    = found_reg.address;
                                out_data_next.found_port    = found_reg.port;
                                out_data_next.found_minor   = found_reg.minor;
                                out_data_next.remaining_ttl = found_reg.life;
                            end
                            else
                            begin
                                out_user_next = STAT_MISS;
                            end
                        end
                        default:
                        begin
                            out_user_next = STAT_IGNORED;
                        end
                    endcase
                end
            end
            default:
            begin
                rd_cnt_next = rd_cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cnt_reg      <= rd_cnt_next;
        chk_idx_reg     <= chk_idx_next;
        func_reg        <= func_next;
        in_reg          <= in_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        min_found_reg   <= min_found_next;
        min_idx_reg     <= min_idx_next;
        min_life_reg    <= min_life_next;
        found_reg       <= found_next;
        cnt_reg         <= cnt_next;
        out_user_reg    <= out_user_next;
        out_data_reg    <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a new result is only produced from the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside done state");

    // the scan pipeline never runs outside the scan state
    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> state_reg == S_SCAN)
        else $error("entry check outside scan");

    // a tick result reports no slot and no lookup data
    a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STAT_TICK) |->
        (m_tdata[SLOT_W-1:0] == '0 && m_tdata[83:4] == '0))
        else $error("tick result carries lookup fields");

    // the expire counter cannot pass the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cnt_reg <= CNT_W'(ENTRIES))
        else $error("expire count overflow");

    // an accepted transaction leaves the idle state on the next edge
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> state_reg != S_IDLE)
        else $error("accepted transaction not started");

endmodule

FILE: rtl/core/srt_ram.sv
// srt_ram: generic single write, single read port ram with registered read
// no dependencies
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: test/testbench.sv
// testbench: self-checking stream test of service_registry_ttl_table_unit
// depends on srt_pkg and the unit's rtl; keeps its own copy of the table to
// predict every result and compares each m_tdata/m_tuser transaction field by field
module testbench;
    import srt_pkg::*;

    localparam int LIMIT = 600000;
    localparam int POOL  = 24;

    typedef struct packed {
        status_t status;
        out_t    data;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [2:0]        m_tuser;

    // predicted registry contents
    logic              svc_valid [ENTRIES];
    logic [LIFE_W-1:0] svc_life  [ENTRIES];
    logic [15:0]       svc_sid   [ENTRIES];
    logic [15:0]       svc_iid   [ENTRIES];
    logic [7:0]        svc_major [ENTRIES];
    logic [7:0]        svc_minor [ENTRIES];
    logic [31:0]       svc_addr  [ENTRIES];
    logic [15:0]       svc_port  [ENTRIES];

    result_t pending_results[$];
    int      errors;
    int      cycles;
    int      burst_left;

    service_registry_ttl_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_service(input logic [15:0] sid, input logic [15:0] iid,
                                        input logic [7:0] maj);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (svc_valid[i] && svc_sid[i] == sid && svc_iid[i] == iid && svc_major[i] == maj)
                return i;
        end
        return -1;
    endfunction

    function automatic void store_entry(input int k, input in_t d);
        svc_valid[k] = 1'b1;
        svc_life[k]  = d.ttl;
        svc_sid[k]   = d.srv;
        svc_iid[k]   = d.inst;
        svc_major[k] = d.major;
        svc_minor[k] = d.minor;
        svc_addr[k]  = d.ipv4;
        svc_port[k]  = d.port;
    endfunction

    // applies one transaction to the predicted table and returns its result
    function automatic void registry_apply(input func_t f, input in_t d, output result_t r);
        int k;
        int target;
        logic [EXP_W-1:0] expired;
        r = '0;
        r.status = STAT_IGNORED;
        expired = '0;
        k = find_service(d.srv, d.inst, d.major);
        case (f)
            FUNC_OFFER:
            begin
                if (k >= 0)
                begin
                    r.data.slot = 4'(k);
                    if (d.ttl == '0)
                    begin
                        svc_valid[k] = 1'b0;
                        svc_life[k]  = '0;
                        r.status = STAT_REMOVED;
                    end
                    else
                    begin
                        store_entry(k, d);
                        r.status = STAT_UPDATED;
                    end
                end
                else if (d.ttl != '0)
                begin
                    target = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (!svc_valid[i] && target < 0)
                            target = i;
                    if (target >= 0)
                        r.status = STAT_INSERTED;
                    else
                    begin
                        // table full: smallest lifetime goes, lowest index on a tie
                        target = 0;
                        for (int i = 1; i < ENTRIES; i++)
                            if (svc_life[i] < svc_life[target])
                                target = i;
                        r.status = STAT_EVICTED;
                    end
                    store_entry(target, d);
                    r.data.slot = 4'(target);
                end
            end
            FUNC_TICK:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (svc_valid[i])
                    begin
                        svc_life[i] = (svc_life[i] > d.elapsed_seconds) ?
                                      svc_life[i] - d.elapsed_seconds : '0;
                        if (svc_life[i] == '0)
                        begin
                            svc_valid[i] = 1'b0;
                            expired++;
                        end
                    end
                end
                r.status = STAT_TICK;
                r.data.expired_count = expired;
            end
            FUNC_LOOKUP:
            begin
                if (k >= 0)
                begin
                    r.status             = STAT_HIT;
                    r.data.slot          = 4'(k);
                    r.data.found_ipv4    = svc_addr[k];
                    r.data.found_port    = svc_port[k];
                    r.data.found_minor   = svc_minor[k];
                    r.data.remaining_ttl = svc_life[k];
                end
                else
                    r.status = STAT_MISS;
            end
            default:
            begin
                r.status = STAT_IGNORED;
            end
        endcase
    endfunction

    function automatic in_t make_item(input logic [15:0] sid, input logic [15:0] iid,
                                      input logic [7:0] maj, input logic [7:0] mnr,
                                      input logic [23:0] ttl, input logic [31:0] ip,
                                      input logic [15:0] prt, input logic [15:0] el);
        in_t d;
        d.srv             = sid;
        d.inst            = iid;
        d.major           = maj;
        d.minor           = mnr;
        d.ttl             = ttl;
        d.ipv4            = ip;
        d.port            = prt;
        d.elapsed_seconds = el;
        return d;
    endfunction

    function automatic in_t random_item();
        return make_item(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                         24'($urandom), $urandom, 16'($urandom), 16'($urandom));
    endfunction

    function automatic logic [23:0] pick_ttl();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return 24'($urandom_range(1, 64));
        else if (r < 90)
            return 24'($urandom_range(65, 65535));
        else
            return 24'($urandom);
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 80)
            return 16'($urandom_range(1, 16));
        else if (r < 95)
            return 16'($urandom);
        else
            return 16'hFFFF;
    endfunction

    // drives one transaction, with bursts and random gaps in between
    task automatic send_item(input func_t f, input in_t d);
        result_t want;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        registry_apply(f, d, want);
        pending_results.push_back(want);
    endtask

    task automatic test_insert_lookup();
        send_item(FUNC_OFFER, make_item(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 24'hFFFFFF,
                                        32'hFFFFFFFF, 16'hFFFF, 16'hFFFF));
        send_item(FUNC_OFFER, make_item('0, '0, '0, '0, 24'd1, '0, '0, '0));
        send_item(FUNC_LOOKUP, make_item(16'hFFFF, 16'hFFFF, 8'hFF, '0, '0, '0, '0, '0));
        send_item(FUNC_LOOKUP, make_item('0, '0, '0, 8'hFF, 24'hFFFFFF, '1, '1, '1));
        send_item(FUNC_LOOKUP, random_item());
        // update overwrites minor, lifetime and endpoint
        send_item(FUNC_OFFER, make_item(16'hFFFF, 16'hFFFF, 8'hFF, 8'd5, 24'd100,
                                        $urandom, 16'($urandom), '0));
        send_item(FUNC_LOOKUP, make_item(16'hFFFF, 16'hFFFF, 8'hFF, '0, '0, '0, '0, '0));
    endtask

    task automatic test_stop_offer();
        send_item(FUNC_OFFER, make_item('0, '0, '0, 8'd9, '0, $urandom, 16'($urandom), '0));
        send_item(FUNC_LOOKUP, make_item('0, '0, '0, '0, '0, '0, '0, '0));
        // unknown key with zero lifetime changes nothing
        send_item(FUNC_OFFER, make_item('0, '0, '0, 8'd9, '0, $urandom, 16'($urandom), '0));
        send_item(FUNC_NONE, make_item('1, '1, '1, '1, '1, '1, '1, '1));
    endtask

    task automatic test_tick();
        send_item(FUNC_TICK, make_item('0, '0, '0, '0, '0, '0, '0, '0));
        send_item(FUNC_OFFER, make_item('0, '0, '0, 8'd3, 24'd1, $urandom, 16'($urandom), '0));
        send_item(FUNC_TICK, make_item('0, '0, '0, '0, '0, '0, '0, 16'd1));
        send_item(FUNC_LOOKUP, make_item(16'hFFFF, 16'hFFFF, 8'hFF, '0, '0, '0, '0, '0));
        send_item(FUNC_TICK, make_item('0, '0, '0, '0, '0, '0, '0, 16'hFFFF));
        send_item(FUNC_LOOKUP, make_item(16'hFFFF, 16'hFFFF, 8'hFF, '0, '0, '0, '0, '0));
    endtask

    // overfills the table with short, often equal lifetimes
    task automatic test_eviction();
        in_t d;
        repeat (ENTRIES + 6)
        begin
            d = random_item();
            d.ttl = 24'($urandom_range(1, 8));
            send_item(FUNC_OFFER, d);
        end
        repeat (3)
            send_item(FUNC_TICK, make_item('0, '0, '0, '0, '0, '0, '0, 16'd1));
    endtask

    task automatic test_random(input int count);
        logic [15:0] pool_sid   [POOL];
        logic [15:0] pool_iid   [POOL];
        logic [7:0]  pool_major [POOL];
        in_t   d;
        func_t f;
        int    sel;
        int    p;
        for (int i = 0; i < POOL; i++)
        begin
            pool_sid[i]   = 16'($urandom);
            pool_iid[i]   = 16'($urandom);
            pool_major[i] = 8'($urandom);
        end
        repeat (count)
        begin
            d   = random_item();
            p   = $urandom_range(0, POOL - 1);
            sel = $urandom_range(0, 99);
            if (sel < 45)
            begin
                f = FUNC_OFFER;
                d.ttl = pick_ttl();
            end
            else if (sel < 60)
            begin
                f = FUNC_TICK;
                d.elapsed_seconds = pick_elapsed();
            end
            else if (sel < 95)
                f = FUNC_LOOKUP;
            else
                f = FUNC_NONE;
            // mostly known keys so updates, removals and hits happen
            if ($urandom_range(0, 5) != 0)
            begin
                d.srv   = pool_sid[p];
                d.inst  = pool_iid[p];
                d.major = pool_major[p];
            end
            send_item(f, d);
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want_v,
                                        input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        out_t    got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing pending: status %0d", m_tuser);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("slot", 64'(want.data.slot), 64'(got.slot));
                check_field("found_ipv4", 64'(want.data.found_ipv4), 64'(got.found_ipv4));
                check_field("found_port", 64'(want.data.found_port), 64'(got.found_port));
                check_field("found_minor", 64'(want.data.found_minor),
                            64'(got.found_minor));
                check_field("remaining_ttl", 64'(want.data.remaining_ttl),
                            64'(got.remaining_ttl));
                check_field("expired_count", 64'(want.data.expired_count),
                            64'(got.expired_count));
            end
        end
    end

    // receiver stalls in runs of different flavors, including always ready
    initial
    begin
        int mode;
        int run;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 60);
            repeat (run)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 9) == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[service_registry_ttl_table_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        errors     = 0;
        cycles     = 0;
        burst_left = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = FUNC_OFFER;
        for (int i = 0; i < ENTRIES; i++)
        begin
            svc_valid[i] = 1'b0;
            svc_life[i]  = '0;
            svc_sid[i]   = '0;
            svc_iid[i]   = '0;
            svc_major[i] = '0;
            svc_minor[i] = '0;
            svc_addr[i]  = '0;
            svc_port[i]  = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_insert_lookup();
        test_stop_offer();
        test_tick();
        test_eviction();
        test_random(800);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 8) @(posedge clk);
        if (errors == 0)
            $display("[service_registry_ttl_table_unit] OK");
        else
            $display("[service_registry_ttl_table_unit] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/service_registry_ttl_table_unit.sv
test/testbench.sv
